// ===== hdl/median_dual_area_accumulator_defines.svh =====
// Assertion macros for the median dual area accumulator.
`ifndef MEDIAN_DUAL_AREA_ACCUMULATOR_DEFINES_SVH
`define MEDIAN_DUAL_AREA_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MDA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mda: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MDA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mda: next-cycle check failed");

`endif

// ===== hdl/mda_pkg.sv =====
// Shared constants, types and helpers for the median dual area accumulator.
`default_nettype none
package mda_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int CORNERS    = 3;
	localparam int COORD_BITS = 24;

	localparam int NODE_FW  = 12;                    // node field width
	localparam int COORD_FW = 24;                    // coordinate field width
	localparam int NODE_AW  = $clog2(NODE_COUNT);    // table index width
	localparam int CIDX_W   = $clog2(CORNERS);       // corner index width
	localparam int AREA_W   = 63;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	localparam int OPD_W   = COORD_BITS + 2;         // multiplier operand width
	localparam int PROD_W  = 2 * OPD_W;
	localparam int DET_W   = PROD_W + 1;
	localparam int MAG6_W  = DET_W + 3;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_AB,
		ST_MUL_CD,
		ST_MAG,
		ST_UPD,
		ST_RD_REQ,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic              mul_en;
		logic              op_cd;
		logic              mag_en;
		logic              rd_en;
		logic              rd_query;
		logic              upd_en;
		logic              clr_en;
		logic [NODE_AW-1:0] clr_addr;
		logic [CIDX_W-1:0]  corner;
		logic              out_load;
	} ctl_t;

	function automatic logic node_ok(input logic [NODE_FW-1:0] node);
		return 32'(node) < NODE_COUNT;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [COORD_FW-1:0] raw);
		return signed'(COORD_BITS'(raw));
	endfunction

endpackage
`default_nettype wire

// ===== hdl/median_dual_area_accumulator.sv =====
// Top level of the median dual area accumulator.
`default_nettype none
`include "median_dual_area_accumulator_defines.svh"
// Median dual area accumulator. Each input transfer is either a triangle add
// (opcode 0) or a node read (opcode 1). An add computes, for each corner, six
// times the magnitude of D = (2Px-Qx-Rx)*(Ry-Qy) + (Qx-Rx)*(2Py-Qy-Ry), which
// is the corner's median dual area scaled by 72, and adds it into that node's
// 63-bit table entry; an entry that would reach 2^63-1 sticks there and its
// saturation mark stays set until reset. Adds give no output transfer; a read
// gives one (node_area, saturated), zero for a node outside the table.
// Sequencing: after reset a clearing pass writes zero to all 4096 table
// entries, one per cycle, with in_stall high throughout. The block takes one
// item at a time. A triangle holds in_stall high after its transfer through,
// per corner, two passes on the one shared multiplier, a magnitude step and
// a table read-modify-write. A read holds it through a table read step and a
// read-out step that waits while the output register is held by out_stall.
// The output register lets a finished result wait while the next item comes in.
module median_dual_area_accumulator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            opcode,
	input  wire logic [mda_pkg::NODE_FW-1:0]     node_a,
	input  wire logic [mda_pkg::NODE_FW-1:0]     node_b,
	input  wire logic [mda_pkg::NODE_FW-1:0]     node_c,
	input  wire logic signed [mda_pkg::COORD_FW-1:0] xa,
	input  wire logic signed [mda_pkg::COORD_FW-1:0] ya,
	input  wire logic signed [mda_pkg::COORD_FW-1:0] xb,
	input  wire logic signed [mda_pkg::COORD_FW-1:0] yb,
	input  wire logic signed [mda_pkg::COORD_FW-1:0] xc,
	input  wire logic signed [mda_pkg::COORD_FW-1:0] yc,
	input  wire logic [mda_pkg::NODE_FW-1:0]     query_node,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [mda_pkg::AREA_W-1:0]           node_area,
	output logic                                 saturated
);
	import mda_pkg::*;

	state_t st;
	ctl_t   ctl;

	logic in_fire;
	logic out_free;

	// latched item
	logic [NODE_FW-1:0]  node_a_q, node_b_q, node_c_q, query_q;
	logic [COORD_FW-1:0] xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;

	logic [NODE_FW-1:0]  rd_node;
	logic [AREA_W-1:0]   amount;
	logic [AREA_W-1:0]   rd_area;
	logic                rd_sat;

	// output register
	logic                out_valid_q;
	logic [AREA_W-1:0]   node_area_q;
	logic                saturated_q;

	assign in_stall = (st != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			node_a_q <= node_a;
			node_b_q <= node_b;
			node_c_q <= node_c;
			query_q  <= query_node;
			xa_q     <= xa;
			ya_q     <= ya;
			xb_q     <= xb;
			yb_q     <= yb;
			xc_q     <= xc;
			yc_q     <= yc;
		end
	end

	mda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_read  (opcode == OP_READ),
		.out_free (out_free),
		.st       (st),
		.ctl      (ctl)
	);

	mda_corner_unit u_corner (
		.clk    (clk),
		.ctl    (ctl),
		.xa     (coord_of(xa_q)),
		.ya     (coord_of(ya_q)),
		.xb     (coord_of(xb_q)),
		.yb     (coord_of(yb_q)),
		.xc     (coord_of(xc_q)),
		.yc     (coord_of(yc_q)),
		.amount (amount)
	);

	// table address: the query on a read, else the current corner's node
	always_comb begin
		if (ctl.rd_query) begin
			rd_node = query_q;
		end else begin
			case (ctl.corner)
				CIDX_W'(0): rd_node = node_a_q;
				CIDX_W'(1): rd_node = node_b_q;
				default:    rd_node = node_c_q;
			endcase
		end
	end

	mda_table u_table (
		.clk     (clk),
		.ctl     (ctl),
		.rd_node (rd_node),
		.amount  (amount),
		.rd_area (rd_area),
		.rd_sat  (rd_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			node_area_q <= rd_area;
			saturated_q <= rd_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign node_area = node_area_q;
	assign saturated = saturated_q;

	// a read transfer goes straight to the table read
	`MDA_ASSERT_NEXT(a_read_starts, in_fire && (opcode == OP_READ), st == ST_RD_REQ)
	// a triangle transfer starts on the first corner's first product
	`MDA_ASSERT_NEXT(a_add_starts, in_fire && (opcode == OP_ADD),
		(st == ST_MUL_AB) && (ctl.corner == '0))
	// a result only ever comes from the read-out step
	`MDA_ASSERT_NOW(a_out_from_read, $rose(out_valid_q), $past(st) == ST_RD_OUT)
	// no table update while the clearing pass runs
	`MDA_ASSERT_NOW(a_no_upd_in_clear, st == ST_CLEAR, !ctl.upd_en && !ctl.rd_en && in_stall)

endmodule
`default_nettype wire

// ===== hdl/mda_ctrl.sv =====
// Sequencer for the median dual area accumulator.
`default_nettype none
module mda_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic            in_read,
	input  wire logic            out_free,
	output mda_pkg::state_t      st,
	output mda_pkg::ctl_t        ctl
);
	import mda_pkg::*;

	state_t              state_q, state_d;
	logic [CIDX_W-1:0]   corner_q, corner_d;
	logic [NODE_AW-1:0]  clr_cnt_q;

	localparam logic [CIDX_W-1:0]  LAST_CORNER = CIDX_W'(CORNERS - 1);
	localparam logic [NODE_AW-1:0] LAST_NODE   = NODE_AW'(NODE_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			corner_q  <= '0;
			clr_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		corner_d = corner_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_NODE)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					corner_d = '0;
					state_d  = in_read ? ST_RD_REQ : ST_MUL_AB;
				end
			end
			ST_MUL_AB: state_d = ST_MUL_CD;
			ST_MUL_CD: state_d = ST_MAG;
			ST_MAG:    state_d = ST_UPD;
			ST_UPD: begin
				if (corner_q == LAST_CORNER) begin
					state_d = ST_IDLE;
				end else begin
					corner_d = corner_q + 1'b1;
					state_d  = ST_MUL_AB;
				end
			end
			ST_RD_REQ: state_d = ST_RD_OUT;
			ST_RD_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl          = '0;
		ctl.clr_addr = clr_cnt_q;
		ctl.corner   = corner_q;
		unique case (state_q)
			ST_CLEAR:  ctl.clr_en = 1'b1;
			ST_IDLE:   ;
			ST_MUL_AB: ctl.mul_en = 1'b1;
			ST_MUL_CD: begin
				ctl.mul_en = 1'b1;
				ctl.op_cd  = 1'b1;
				ctl.rd_en  = 1'b1;
			end
			ST_MAG:    ctl.mag_en = 1'b1;
			ST_UPD:    ctl.upd_en = 1'b1;
			ST_RD_REQ: begin
				ctl.rd_en    = 1'b1;
				ctl.rd_query = 1'b1;
			end
			ST_RD_OUT: ctl.out_load = out_free;
		endcase
	end

	assign st = state_q;

endmodule
`default_nettype wire

// ===== hdl/mda_corner_unit.sv =====
// Shared multiplier and magnitude path: 6*|D| for one corner at a time.
`default_nettype none
module mda_corner_unit (
	input  wire logic                                   clk,
	input  wire mda_pkg::ctl_t                          ctl,
	input  wire logic signed [mda_pkg::COORD_BITS-1:0]  xa,
	input  wire logic signed [mda_pkg::COORD_BITS-1:0]  ya,
	input  wire logic signed [mda_pkg::COORD_BITS-1:0]  xb,
	input  wire logic signed [mda_pkg::COORD_BITS-1:0]  yb,
	input  wire logic signed [mda_pkg::COORD_BITS-1:0]  xc,
	input  wire logic signed [mda_pkg::COORD_BITS-1:0]  yc,
	output logic [mda_pkg::AREA_W-1:0]                  amount
);
	import mda_pkg::*;

	logic signed [OPD_W-1:0]  px, py, qx, qy, rx, ry;
	logic signed [OPD_W-1:0]  opx, opy;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic signed [DET_W-1:0]  det;
	logic [DET_W-1:0]         det_abs, mag_q;
	logic [MAG6_W-1:0]        mag6;

	// corner P with neighbours Q and R
	always_comb begin
		case (ctl.corner)
			CIDX_W'(0): begin
				px = OPD_W'(xa); py = OPD_W'(ya);
				qx = OPD_W'(xb); qy = OPD_W'(yb);
				rx = OPD_W'(xc); ry = OPD_W'(yc);
			end
			CIDX_W'(1): begin
				px = OPD_W'(xb); py = OPD_W'(yb);
				qx = OPD_W'(xa); qy = OPD_W'(ya);
				rx = OPD_W'(xc); ry = OPD_W'(yc);
			end
			default: begin
				px = OPD_W'(xc); py = OPD_W'(yc);
				qx = OPD_W'(xa); qy = OPD_W'(ya);
				rx = OPD_W'(xb); ry = OPD_W'(yb);
			end
		endcase
	end

	// first pass: (2Px-Qx-Rx)*(Ry-Qy); second: (Qx-Rx)*(2Py-Qy-Ry)
	assign opx = ctl.op_cd ? (qx - rx) : ((px <<< 1) - qx - rx);
	assign opy = ctl.op_cd ? ((py <<< 1) - qy - ry) : (ry - qy);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= opx * opy;
			if (ctl.op_cd)
				acc_q <= prod_q;
		end
		if (ctl.mag_en)
			mag_q <= det_abs;
	end

	assign det     = DET_W'(acc_q) + DET_W'(prod_q);
	assign det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
	assign mag6    = MAG6_W'({mag_q, 2'b00}) + MAG6_W'({mag_q, 1'b0});
	assign amount  = AREA_W'(mag6);

endmodule
`default_nettype wire

// ===== hdl/mda_table.sv =====
// Per-node area table with saturating read-modify-write and clear port.
`default_nettype none
module mda_table (
	input  wire logic                          clk,
	input  wire mda_pkg::ctl_t                 ctl,
	input  wire logic [mda_pkg::NODE_FW-1:0]   rd_node,
	input  wire logic [mda_pkg::AREA_W-1:0]    amount,
	output logic [mda_pkg::AREA_W-1:0]         rd_area,
	output logic                               rd_sat
);
	import mda_pkg::*;

	// word layout: saturation mark on top, area below
	logic [AREA_W:0]      mem [NODE_COUNT];
	logic [AREA_W:0]      rdata_q;
	logic [NODE_AW-1:0]   addr_q;
	logic                 ok_q;
	logic [NODE_AW-1:0]   rd_idx;
	logic [AREA_W:0]      sum;
	logic                 sat_hit;
	logic [AREA_W:0]      new_word;

	assign rd_idx = NODE_AW'(rd_node);

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_idx];
			addr_q  <= rd_idx;
			ok_q    <= node_ok(rd_node);
		end
		if (ctl.clr_en)
			mem[ctl.clr_addr] <= '0;
		else if (ctl.upd_en && ok_q)
			mem[addr_q] <= new_word;
	end

	assign sum      = {1'b0, rdata_q[AREA_W-1:0]} + {1'b0, amount};
	assign sat_hit  = sum >= {1'b0, AREA_MAX};
	assign new_word = sat_hit ? {1'b1, AREA_MAX} : {rdata_q[AREA_W], sum[AREA_W-1:0]};

	assign rd_area = ok_q ? rdata_q[AREA_W-1:0] : '0;
	assign rd_sat  = ok_q & rdata_q[AREA_W];

endmodule
`default_nettype wire
